[rtl/pwc_pkg.sv]
// shared types and constants for the prefix word completion block
// no dependencies
`default_nettype none
package pwc_pkg;
    localparam int MAX_WORDS_DEF    = 64;
    localparam int MAX_WORD_LEN_DEF = 16;

    localparam logic [1:0] MODE_TEXT  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    // controller to datapath commands
    typedef struct packed {
        logic take_char;     // append char to pending word or query
        logic clear_all;     // empty table, pending word and query
        logic scan_init;     // reset scan pointer and best tracker
        logic scan_step;     // compare current slot and advance
        logic close_apply;   // commit result of a close scan
        logic emit_init;     // point emit counter at first char
        logic emit_step;     // advance emit counter
        logic query_done;    // drop the query after a search
    } pwc_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic scan_done;     // scan pointer has passed the last word
        logic pending_empty; // no pending text characters
        logic have_best;     // search found a match
        logic emit_last;     // current emit char is the final one
    } pwc_stat_t;

    function automatic logic is_sep(input logic [7:0] c);
        return (c == CH_COMMA) || (c == CH_DOT) || (c == CH_SPACE);
    endfunction
endpackage
`default_nettype wire

[rtl/prefix_word_completion.sv]
// top level of the prefix word completion block, built on pwc_pkg, pwc_ctrl, pwc_datapath
// a text or clear word leaves the block idle; a closing separator with pending text holds busy
// through the close scan and the commit; a query end word scans, loads the winner, then emits
// one char a cycle
// throughput: one word per cycle while not busy
// reset: async active low clears counts and flags; the receiver cannot stall results
`default_nettype none
module prefix_word_completion #(
    parameter int MAX_WORDS    = pwc_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = pwc_pkg::MAX_WORD_LEN_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    output      logic       busy,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] char_in,
    input  wire logic       query_end,
    output      logic       valid,
    output      logic [7:0] char_out,
    output      logic       run_last,
    output      logic       found,
    output      logic       overflow_seen
);
    import pwc_pkg::*;

    pwc_cmd_t  cmd;
    pwc_stat_t stat;

    // controller sequences scans over the table and the emit run
    pwc_ctrl u_ctrl (
        .clk, .rst_n, .start, .mode, .char_in, .query_end,
        .stat, .cmd, .busy, .valid, .run_last, .found
    );

    // datapath holds the word table and the search tracker
    pwc_datapath #(
        .MAX_WORDS(MAX_WORDS), .MAX_WORD_LEN(MAX_WORD_LEN)
    ) u_dp (
        .clk, .rst_n, .char_in,
        .is_query(mode == MODE_QUERY),
        .cmd, .stat, .char_out, .overflow_seen
    );
endmodule
`default_nettype wire

[rtl/pwc_datapath.sv]
// datapath: word table memories, pending and query buffers, scan and emit
// depends on pwc_pkg
`default_nettype none
module pwc_datapath #(
    parameter int MAX_WORDS    = pwc_pkg::MAX_WORDS_DEF,
    parameter int MAX_WORD_LEN = pwc_pkg::MAX_WORD_LEN_DEF
) (
    input  wire                logic     clk,
    input  wire                logic     rst_n,
    input  wire                logic [7:0] char_in,
    input  wire                logic     is_query,
    input  wire                pwc_pkg::pwc_cmd_t  cmd,
    output                     pwc_pkg::pwc_stat_t stat,
    output                     logic [7:0] char_out,
    output                     logic     overflow_seen
);
    import pwc_pkg::*;

    localparam int WW = $clog2(MAX_WORDS);
    localparam int LW = $clog2(MAX_WORD_LEN);
    localparam int CW = $clog2(MAX_WORDS + 1);
    localparam int NW = $clog2(MAX_WORD_LEN + 1);

    // word table: chars as one row per word so a slot compares in one read
    logic [MAX_WORD_LEN*8-1:0] row_mem [MAX_WORDS];
    logic [NW-1:0]             len_mem [MAX_WORDS];
    logic [15:0]               cnt_mem [MAX_WORDS];

    logic [CW-1:0] stored_reg, stored_next;
    logic [7:0]    pend_reg [MAX_WORD_LEN];
    logic [NW-1:0] pend_len_reg;
    logic [7:0]    qry_reg  [MAX_WORD_LEN];
    logic [NW-1:0] qry_len_reg;
    logic          ovf_reg;

    logic [CW-1:0] ptr_reg;
    logic          rd_valid_reg;
    logic [MAX_WORD_LEN*8-1:0] rd_row_reg;
    logic [NW-1:0] rd_len_reg;
    logic [15:0]   rd_cnt_reg;
    logic [WW-1:0] rd_idx_reg;

    logic          have_reg;
    logic [WW-1:0] best_reg;
    logic [NW-1:0] best_extra_reg;
    logic [15:0]   best_cnt_reg;
    logic          hit_reg;
    logic [WW-1:0] hit_idx_reg;
    logic [15:0]   hit_cnt_reg;

    logic [NW-1:0] emit_reg;
    logic [NW-1:0] emit_len_reg;
    logic [MAX_WORD_LEN*8-1:0] emit_row_reg;

    logic eq_pend, pre_qry;
    logic [NW-1:0] extra;

    always_comb
    begin
        eq_pend = (rd_len_reg == pend_len_reg);
        pre_qry = (qry_len_reg <= rd_len_reg);
        for (int i = 0; i < MAX_WORD_LEN; i++)
        begin
            if (NW'(i) < pend_len_reg && rd_row_reg[i*8 +: 8] != pend_reg[i])
                eq_pend = 1'b0;
            if (NW'(i) < qry_len_reg && rd_row_reg[i*8 +: 8] != qry_reg[i])
                pre_qry = 1'b0;
        end
        extra = rd_len_reg - qry_len_reg;
    end

    // memory writes and registered reads
    logic [MAX_WORD_LEN*8-1:0] pend_row;
    always_comb
    begin
        for (int i = 0; i < MAX_WORD_LEN; i++)
            pend_row[i*8 +: 8] = pend_reg[i];
    end

    logic new_word;
    assign new_word = cmd.close_apply && !hit_reg && stored_reg != CW'(MAX_WORDS);

    always_ff @(posedge clk)
    begin
        if (new_word)
        begin
            row_mem[stored_reg[WW-1:0]] <= pend_row;
            len_mem[stored_reg[WW-1:0]] <= pend_len_reg;
        end
        if (new_word)
            cnt_mem[stored_reg[WW-1:0]] <= 16'd1;
        else if (cmd.close_apply && hit_reg && hit_cnt_reg != COUNT_MAX)
            cnt_mem[hit_idx_reg] <= hit_cnt_reg + 16'd1;
        rd_row_reg <= row_mem[ptr_reg[WW-1:0]];
        rd_len_reg <= len_mem[ptr_reg[WW-1:0]];
        rd_cnt_reg <= cnt_mem[ptr_reg[WW-1:0]];
        rd_idx_reg <= ptr_reg[WW-1:0];
        if (cmd.emit_init)
            emit_row_reg <= row_mem[best_reg];
    end

    assign stored_next = new_word ? stored_reg + CW'(1) : stored_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stored_reg   <= '0;
            pend_len_reg <= '0;
            qry_len_reg  <= '0;
            ovf_reg      <= 1'b0;
            ptr_reg      <= '0;
            rd_valid_reg <= 1'b0;
            have_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            emit_reg     <= '0;
            emit_len_reg <= '0;
        end
        else
        begin
            stored_reg <= stored_next;
            if (cmd.clear_all)
            begin
                stored_reg   <= '0;
                pend_len_reg <= '0;
                qry_len_reg  <= '0;
            end
            if (cmd.take_char)
            begin
                if (is_query)
                begin
                    if (qry_len_reg != NW'(MAX_WORD_LEN))
                    begin
                        qry_reg[qry_len_reg[LW-1:0]] <= char_in;
                        qry_len_reg <= qry_len_reg + NW'(1);
                    end
                    else
                        ovf_reg <= 1'b1;
                end
                else
                begin
                    if (pend_len_reg != NW'(MAX_WORD_LEN))
                    begin
                        pend_reg[pend_len_reg[LW-1:0]] <= char_in;
                        pend_len_reg <= pend_len_reg + NW'(1);
                    end
                    else
                        ovf_reg <= 1'b1;
                end
            end
            if (cmd.close_apply)
            begin
                pend_len_reg <= '0;
                if (!hit_reg && stored_reg == CW'(MAX_WORDS))
                    ovf_reg <= 1'b1;
            end
            if (cmd.query_done)
                qry_len_reg <= '0;
            if (cmd.scan_init)
            begin
                ptr_reg      <= '0;
                rd_valid_reg <= 1'b0;
                have_reg     <= 1'b0;
                hit_reg      <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                rd_valid_reg <= (ptr_reg < stored_reg);
                if (ptr_reg < stored_reg)
                    ptr_reg <= ptr_reg + CW'(1);
                if (rd_valid_reg)
                begin
                    if (eq_pend && !hit_reg)
                    begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        hit_cnt_reg <= rd_cnt_reg;
                    end
                    if (pre_qry && (!have_reg || extra < best_extra_reg ||
                        (extra == best_extra_reg && rd_cnt_reg > best_cnt_reg)))
                    begin
                        have_reg       <= 1'b1;
                        best_reg       <= rd_idx_reg;
                        best_extra_reg <= extra;
                        best_cnt_reg   <= rd_cnt_reg;
                    end
                end
            end
            if (cmd.emit_init)
            begin
                emit_reg     <= '0;
                emit_len_reg <= len_mem[best_reg];
            end
            else if (cmd.emit_step)
                emit_reg <= emit_reg + NW'(1);
        end
    end

    assign stat.scan_done     = !rd_valid_reg && ptr_reg >= stored_reg;
    assign stat.pending_empty = (pend_len_reg == '0);
    assign stat.have_best     = have_reg;
    assign stat.emit_last     = (emit_reg + NW'(1) == emit_len_reg);
    assign char_out      = have_reg ? emit_row_reg[emit_reg[LW-1:0]*8 +: 8] : 8'd0;
    assign overflow_seen = ovf_reg;
endmodule
`default_nettype wire

[rtl/pwc_ctrl.sv]
// controller state machine for the prefix word completion block
// depends on pwc_pkg
`default_nettype none
module pwc_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire logic [1:0] mode,
    input  wire logic [7:0] char_in,
    input  wire logic query_end,
    input  wire pwc_pkg::pwc_stat_t stat,
    output      pwc_pkg::pwc_cmd_t  cmd,
    output      logic busy,
    output      logic valid,
    output      logic run_last,
    output      logic found
);
    import pwc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CSCAN = 3'd1;
    localparam logic [2:0] S_CAPP  = 3'd2;
    localparam logic [2:0] S_QSCAN = 3'd3;
    localparam logic [2:0] S_EINIT = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        valid      = 1'b0;
        run_last   = 1'b0;
        found      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (mode)
                        MODE_TEXT:
                        begin
                            if (is_sep(char_in))
                            begin
                                if (!stat.pending_empty)
                                begin
                                    cmd.scan_init = 1'b1;
                                    state_next    = S_CSCAN;
                                end
                            end
                            else
                                cmd.take_char = 1'b1;
                        end
                        MODE_QUERY:
                        begin
                            cmd.take_char = 1'b1;
                            if (query_end)
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_QSCAN;
                            end
                        end
                        MODE_CLEAR: cmd.clear_all = 1'b1;
                        default: ;
                    endcase
                end
            end
            S_CSCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_CAPP;
            end
            S_CAPP:
            begin
                cmd.close_apply = 1'b1;
                state_next      = S_IDLE;
            end
            S_QSCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                begin
                    cmd.query_done = 1'b1;
                    state_next     = S_EINIT;
                end
            end
            S_EINIT:
            begin
                cmd.emit_init = 1'b1;
                state_next    = S_EMIT;
            end
            S_EMIT:
            begin
                valid = 1'b1;
                found = stat.have_best;
                run_last = !stat.have_best || stat.emit_last;
                cmd.emit_step = 1'b1;
                if (run_last)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

[rtl/pwc_checker.sv]
// port level checks for the prefix word completion block
// depends on prefix_word_completion
`default_nettype none
module pwc_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic valid,
    input wire logic run_last,
    input wire logic found,
    input wire logic [7:0] char_out,
    input wire logic overflow_seen
);
    a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> busy) else $error("result while idle");
    a_nofound_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !found |-> run_last && char_out == 8'd0) else $error("bad no match");
    a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $past(overflow_seen) |-> overflow_seen) else $error("overflow cleared");
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        valid && run_last |=> !valid) else $error("run continues");
    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !busy && !start |=> !busy) else $error("busy without a word");
endmodule

bind prefix_word_completion pwc_checker u_chk (
    .clk, .rst_n, .start, .busy, .valid, .run_last, .found, .char_out, .overflow_seen
);
`default_nettype wire
